/* rtl/rfd_pkg.sv */
// ----------------------------------------------------------------------------
// rfd_pkg: shared types and constants for the radar frame deframer
// Header bytes, frame layout offsets, queue sizing and the stored entry type.
// ----------------------------------------------------------------------------
package rfd_pkg;

  // Default store depth (bytes).
  localparam int unsigned STORE_DEPTH_DEF = 512;

  // Front queue depth, power of two.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Frame sync and type bytes.
  localparam logic [7:0] HDR_FIRST    = 8'hAA;
  localparam logic [7:0] HDR_SECOND   = 8'hFF;
  localparam logic [7:0] TYPE_TARGETS = 8'h03;

  // Header + type + length.
  localparam int unsigned PREFIX_BYTES = 4;

  // Length byte limits: a target frame needs 6, full target data needs 10.
  localparam logic [7:0] MIN_DATA_LEN  = 8'd6;
  localparam logic [7:0] FULL_DATA_LEN = 8'd10;

  // Byte offsets inside a frame, from the first header byte.
  localparam int unsigned OFS_TYPE   = 2;
  localparam int unsigned OFS_LEN    = 3;
  localparam int unsigned OFS_TGT    = 4;
  localparam int unsigned OFS_DIST_L = 5;
  localparam int unsigned OFS_DIST_H = 6;
  localparam int unsigned OFS_EMOVE  = 7;
  localparam int unsigned OFS_ESTAT  = 8;

  // One stored byte with its sync classification.
  typedef struct packed {
    logic       sync_a;  // byte is the first header byte
    logic       sync_b;  // byte is the second header byte
    logic [7:0] data;
  } rfd_entry_t;

endpackage

/* rtl/radar_frame_deframer.sv */
// ----------------------------------------------------------------------------
// radar_frame_deframer: byte-wise frame sync for a serial radar sensor
// Appends each received byte to a circular store unless full, searches for the
// 0xAA 0xFF header, and reports presence, distance and energies of target frames.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake                 payload
//   -------  ---  ------------------------  ---------------------------------
//   in       in   in_valid_i / in_ready_o   rx_byte_i
//   out      out  out_valid_o / out_ready_i presence_o, target_dist_o,
//                                           move_energy_o, still_energy_o
//
// One word at a time runs through the search engine. While fewer than four
// bytes are stored a word only goes into the store; else the header search
// reads the single-port store one byte per cycle (at most fill = bytes stored),
// then drop and, if enough bytes remain, frame byte fetch and a decision step.
// A 4-deep queue takes words while the engine searches; the result sits in an
// output register, so the engine only stalls when a new result meets a full one.
// Reset (rst_ni low, asynchronous) empties the store, the input queue and the
// output register; no clearing pass is needed, since bytes read beyond those
// stored are never used.
//
module radar_frame_deframer #(
  parameter int unsigned STORE_DEPTH = rfd_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        presence_o,
  output logic [15:0] target_dist_o,
  output logic [7:0]  move_energy_o,
  output logic [7:0]  still_energy_o
);

  // front to back word queue
  logic                q_valid;
  logic                q_ready;  // high only while the engine waits for a word
  rfd_pkg::rfd_entry_t q_entry;

  rfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_entry_o  (q_entry)
  );

  rfd_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_ready_o      (q_ready),
    .q_entry_i      (q_entry),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .presence_o     (presence_o),
    .target_dist_o  (target_dist_o),
    .move_energy_o  (move_energy_o),
    .still_energy_o (still_energy_o)
  );

  // A full input queue always presents a word to the engine.
  a_full_queue_has_word: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid
  ) else $error("input queue full but no word offered to engine");

  // The queue must not drain while the engine is busy.
  a_queue_holds_while_busy: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !q_ready) |=> q_valid
  ) else $error("queued word lost while engine busy");

  // A result only appears at the end of a search pass.
  a_result_from_pass: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!q_ready)
  ) else $error("result raised outside a search pass");

endmodule

/* rtl/rfd_front.sv */
// ----------------------------------------------------------------------------
// rfd_front: input word queue
// Accepts received bytes, tags header bytes, and buffers them for the back end.
// ----------------------------------------------------------------------------
module rfd_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             rx_byte_i,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output rfd_pkg::rfd_entry_t    q_entry_o
);

  localparam int unsigned QAW = $clog2(rfd_pkg::QUEUE_DEPTH);
  localparam int unsigned QCW = $clog2(rfd_pkg::QUEUE_DEPTH + 1);

  rfd_pkg::rfd_entry_t fifo_q [rfd_pkg::QUEUE_DEPTH];
  rfd_pkg::rfd_entry_t in_entry;
  logic [QAW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]      count_q, count_d;
  logic                push, pop;

  // classify on the way in
  always_comb begin
    in_entry.sync_a = (rx_byte_i == rfd_pkg::HDR_FIRST);
    in_entry.sync_b = (rx_byte_i == rfd_pkg::HDR_SECOND);
    in_entry.data   = rx_byte_i;
  end

  assign in_ready_o = (count_q != QCW'(rfd_pkg::QUEUE_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = fifo_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_entry;
    end
  end

endmodule

/* rtl/rfd_back.sv */
// ----------------------------------------------------------------------------
// rfd_back: frame search engine
// Holds the circular byte store, searches for a header per byte once four are
// stored, checks any frame found, and keeps the result in an output register.
// ----------------------------------------------------------------------------
module rfd_back #(
  parameter int unsigned STORE_DEPTH = rfd_pkg::STORE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  rfd_pkg::rfd_entry_t    q_entry_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   presence_o,
  output logic [15:0]            target_dist_o,
  output logic [7:0]             move_energy_o,
  output logic [7:0]             still_energy_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DROP,
    S_FETCH,
    S_DECIDE
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       fill_q, fill_d;
  logic [AW-1:0]       start_q, start_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       rd_idx_q, rd_idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic                prev_a_q, prev_a_d;
  logic [CW-1:0]       hdr_q, hdr_d;
  logic [7:0]          type_q, type_d;
  logic [7:0]          len_q, len_d;
  logic [7:0]          tgt_q, tgt_d;
  logic [7:0]          dist_l_q, dist_l_d;
  logic [7:0]          dist_h_q, dist_h_d;
  logic [7:0]          emove_q, emove_d;
  logic [7:0]          estat_q, estat_d;
  logic                out_valid_q, out_valid_d;
  logic                presence_q, presence_d;
  logic [15:0]         dist_q, dist_d;
  logic [7:0]          em_q, em_d;
  logic [7:0]          es_q, es_d;

  rfd_pkg::rfd_entry_t store_q [STORE_DEPTH];
  rfd_pkg::rfd_entry_t rdata_q;

  logic [CW-1:0]       off;
  logic [AW:0]         pos_sum;
  logic [AW-1:0]       pos;
  logic                wr_en, rd_en;
  logic                full;
  logic [CW-1:0]       fill_new;
  logic [CW-1:0]       fill_left;
  logic [CW-1:0]       total;

  // circular address of an offset from the oldest byte
  always_comb begin
    pos_sum = (AW+1)'(start_q) + (AW+1)'(off);
    if (pos_sum >= (AW+1)'(STORE_DEPTH)) begin
      pos = AW'(pos_sum - (AW+1)'(STORE_DEPTH));
    end else begin
      pos = AW'(pos_sum);
    end
  end

  assign full      = (fill_q == CW'(STORE_DEPTH));
  assign fill_new  = full ? fill_q : fill_q + 1'b1;
  assign fill_left = fill_q - hdr_q;
  assign total     = CW'(len_q) + CW'(rfd_pkg::PREFIX_BYTES);
  assign q_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    start_d     = start_q;
    idx_d       = idx_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = 1'b0;
    prev_a_d    = prev_a_q;
    hdr_d       = hdr_q;
    type_d      = type_q;
    len_d       = len_q;
    tgt_d       = tgt_q;
    dist_l_d    = dist_l_q;
    dist_h_d    = dist_h_q;
    emove_d     = emove_q;
    estat_d     = estat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    presence_d  = presence_q;
    dist_d      = dist_q;
    em_d        = em_q;
    es_d        = es_q;
    off         = idx_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;

    case (state_q)
      S_IDLE: begin
        off = fill_q;
        if (q_valid_i) begin
          wr_en  = !full;
          fill_d = fill_new;
          if (fill_new >= CW'(rfd_pkg::PREFIX_BYTES)) begin
            state_d  = S_SCAN;
            idx_d    = '0;
            prev_a_d = 1'b0;
          end
        end
      end

      S_SCAN: begin
        // one read issued per cycle, checked in the next cycle
        if (idx_q < fill_q) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q;
          idx_d    = idx_q + 1'b1;
        end
        if (rd_vld_q) begin
          prev_a_d = rdata_q.sync_a;
          if (prev_a_q && rdata_q.sync_b && (rd_idx_q != '0)) begin
            hdr_d    = rd_idx_q - 1'b1;
            rd_vld_d = 1'b0;
            state_d  = S_DROP;
          end else if (rd_idx_q == fill_q - 1'b1) begin
            // no header anywhere: empty the store
            fill_d   = '0;
            start_d  = '0;
            rd_vld_d = 1'b0;
            state_d  = S_IDLE;
          end
        end
      end

      S_DROP: begin
        off     = hdr_q;
        start_d = pos;
        fill_d  = fill_left;
        if (fill_left < CW'(rfd_pkg::PREFIX_BYTES)) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = CW'(rfd_pkg::OFS_TYPE);
          state_d = S_FETCH;
        end
      end

      S_FETCH: begin
        // read frame bytes type..static energy; unused ones are ignored later
        if (idx_q <= CW'(rfd_pkg::OFS_ESTAT)) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q;
          idx_d    = idx_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (rd_idx_q == CW'(rfd_pkg::OFS_TYPE)) begin
            type_d = rdata_q.data;
          end else if (rd_idx_q == CW'(rfd_pkg::OFS_LEN)) begin
            len_d = rdata_q.data;
          end else if (rd_idx_q == CW'(rfd_pkg::OFS_TGT)) begin
            tgt_d = rdata_q.data;
          end else if (rd_idx_q == CW'(rfd_pkg::OFS_DIST_L)) begin
            dist_l_d = rdata_q.data;
          end else if (rd_idx_q == CW'(rfd_pkg::OFS_DIST_H)) begin
            dist_h_d = rdata_q.data;
          end else if (rd_idx_q == CW'(rfd_pkg::OFS_EMOVE)) begin
            emove_d = rdata_q.data;
          end else begin
            estat_d  = rdata_q.data;
            rd_vld_d = 1'b0;
            state_d  = S_DECIDE;
          end
        end
      end

      S_DECIDE: begin
        off = CW'(1);
        if (fill_q < total) begin
          state_d = S_IDLE;
        end else if ((len_q >= rfd_pkg::MIN_DATA_LEN) &&
                     (type_q == rfd_pkg::TYPE_TARGETS)) begin
          // wait here until the output register can take the result
          if (!out_valid_q || out_ready_i) begin
            out_valid_d = 1'b1;
            presence_d  = (tgt_q != 8'd0);
            if ((tgt_q != 8'd0) && (len_q >= rfd_pkg::FULL_DATA_LEN)) begin
              dist_d = {dist_h_q, dist_l_q};
              em_d   = emove_q;
              es_d   = estat_q;
            end else begin
              dist_d = '0;
              em_d   = '0;
              es_d   = '0;
            end
            fill_d  = '0;
            start_d = '0;
            state_d = S_IDLE;
          end
        end else begin
          // other complete frame: skip its first byte
          start_d = pos;
          fill_d  = fill_q - 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      start_q     <= '0;
      idx_q       <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      prev_a_q    <= 1'b0;
      hdr_q       <= '0;
      type_q      <= '0;
      len_q       <= '0;
      tgt_q       <= '0;
      dist_l_q    <= '0;
      dist_h_q    <= '0;
      emove_q     <= '0;
      estat_q     <= '0;
      out_valid_q <= 1'b0;
      presence_q  <= 1'b0;
      dist_q      <= '0;
      em_q        <= '0;
      es_q        <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      start_q     <= start_d;
      idx_q       <= idx_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      prev_a_q    <= prev_a_d;
      hdr_q       <= hdr_d;
      type_q      <= type_d;
      len_q       <= len_d;
      tgt_q       <= tgt_d;
      dist_l_q    <= dist_l_d;
      dist_h_q    <= dist_h_d;
      emove_q     <= emove_d;
      estat_q     <= estat_d;
      out_valid_q <= out_valid_d;
      presence_q  <= presence_d;
      dist_q      <= dist_d;
      em_q        <= em_d;
      es_q        <= es_d;
    end
  end

  // byte store: one port, write or registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[pos] <= q_entry_i;
    end
    if (rd_en) begin
      rdata_q <= store_q[pos];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign presence_o     = presence_q;
  assign target_dist_o  = dist_q;
  assign move_energy_o  = em_q;
  assign still_energy_o = es_q;

endmodule
